### rtl/bstu_pkg.sv
package bstu_pkg;

    // Byte-order mark values
    localparam logic [7:0] BOM_FF = 8'hFF;
    localparam logic [7:0] BOM_FE = 8'hFE;
    localparam logic [7:0] BOM_00 = 8'h00;
    localparam logic [7:0] BOM_EF = 8'hEF;
    localparam logic [7:0] BOM_BB = 8'hBB;
    localparam logic [7:0] BOM_BF = 8'hBF;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        MODE_UNDET = 3'd0,
        MODE_PASS  = 3'd1,
        MODE_U16LE = 3'd2,
        MODE_U16BE = 3'd3,
        MODE_U32LE = 3'd4
    } mode_t;

    // Raw bytes are carried as they stand, a code point is encoded by the back
    typedef enum logic {
        KIND_RAW = 1'b0,
        KIND_CP  = 1'b1
    } kind_t;

    // One queued job: up to three raw bytes (first byte in the low lane)
    // or one code point in data[20:0]
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  cnt;
        logic [23:0] data;
        logic        last;
        logic        err;
    } entry_t;

endpackage

### rtl/bstu_front.sv
module bstu_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            queue_full,
    output logic            push,
    output bstu_pkg::entry_t entry
);
    import bstu_pkg::*;

    mode_t       mode_reg, mode_next, mode_s;
    logic [1:0]  count_reg, count_next, count_s;
    logic [7:0]  held0_reg, held0_next, held0_s;
    logic [7:0]  held1_reg, held1_next, held1_s;
    logic [23:0] partial_reg, partial_next, partial_s;
    logic [1:0]  idx_reg, idx_next, idx_s;
    logic [9:0]  hs_reg, hs_next, hs_s;
    logic        pend_reg, pend_next, pend_s;
    logic        failed_reg, failed_next, failed_s;

    logic        accept;
    logic [1:0]  raw_cnt;
    logic [23:0] raw_data;
    logic        u16_go;
    logic [15:0] u16;
    logic        cp_go;
    logic [20:0] cp_val;
    logic        fail_end;

    assign accept = in_valid && !queue_full;

    // Work out the state after this word and what it gives
    always_comb
    begin
        mode_s    = mode_reg;
        count_s   = count_reg;
        held0_s   = held0_reg;
        held1_s   = held1_reg;
        partial_s = partial_reg;
        idx_s     = idx_reg;
        hs_s      = hs_reg;
        pend_s    = pend_reg;
        failed_s  = failed_reg;
        raw_cnt   = 2'd0;
        raw_data  = 24'd0;
        u16_go    = 1'b0;
        u16       = 16'd0;
        cp_go     = 1'b0;
        cp_val    = 21'd0;

        unique case (mode_reg)
            MODE_UNDET:
            begin
                unique case (count_reg)
                    2'd0:
                    begin
                        if (in_byte == BOM_FF || in_byte == BOM_FE || in_byte == BOM_EF)
                        begin
                            held0_s = in_byte;
                            count_s = 2'd1;
                        end
                        else
                        begin
                            raw_cnt  = 2'd1;
                            raw_data = {16'd0, in_byte};
                            mode_s   = MODE_PASS;
                        end
                    end
                    2'd1:
                    begin
                        if ((held0_reg == BOM_FF && in_byte == BOM_FE) ||
                            (held0_reg == BOM_EF && in_byte == BOM_BB))
                        begin
                            held1_s = in_byte;
                            count_s = 2'd2;
                        end
                        else if (held0_reg == BOM_FE && in_byte == BOM_FF)
                        begin
                            mode_s = MODE_U16BE;
                        end
                        else
                        begin
                            raw_cnt  = 2'd2;
                            raw_data = {8'd0, in_byte, held0_reg};
                            mode_s   = MODE_PASS;
                        end
                    end
                    2'd2:
                    begin
                        if (held0_reg == BOM_FF)
                        begin
                            if (in_byte == BOM_00)
                            begin
                                count_s = 2'd3;
                            end
                            else
                            begin
                                mode_s    = MODE_U16LE;
                                partial_s = {16'd0, in_byte};
                                idx_s     = 2'd1;
                            end
                        end
                        else if (in_byte == BOM_BF)
                        begin
                            mode_s = MODE_PASS;
                        end
                        else
                        begin
                            raw_cnt  = 2'd3;
                            raw_data = {in_byte, held1_reg, held0_reg};
                            mode_s   = MODE_PASS;
                        end
                    end
                    default:
                    begin
                        // FF FE 00 seen: a fourth zero means UTF-32LE
                        if (in_byte == BOM_00)
                        begin
                            mode_s = MODE_U32LE;
                        end
                        else
                        begin
                            mode_s = MODE_U16LE;
                            u16_go = 1'b1;
                            u16    = {in_byte, 8'h00};
                        end
                    end
                endcase
            end
            MODE_PASS:
            begin
                raw_cnt  = 2'd1;
                raw_data = {16'd0, in_byte};
            end
            MODE_U16LE, MODE_U16BE:
            begin
                if (!failed_reg)
                begin
                    if (idx_reg == 2'd0)
                    begin
                        partial_s = {16'd0, in_byte};
                        idx_s     = 2'd1;
                    end
                    else
                    begin
                        u16       = (mode_reg == MODE_U16LE) ? {in_byte, partial_reg[7:0]}
                                                             : {partial_reg[7:0], in_byte};
                        u16_go    = 1'b1;
                        partial_s = 24'd0;
                        idx_s     = 2'd0;
                    end
                end
            end
            MODE_U32LE:
            begin
                if (!failed_reg)
                begin
                    if (idx_reg != 2'd3)
                    begin
                        partial_s[8*idx_reg +: 8] = in_byte;
                        idx_s = idx_reg + 2'd1;
                    end
                    else
                    begin
                        partial_s = 24'd0;
                        idx_s     = 2'd0;
                        // Reject values above 10FFFF and surrogate values
                        if (in_byte != 8'd0 || partial_reg[23:16] > 8'h10 ||
                            (partial_reg[23:16] == 8'd0 && partial_reg[15:11] == 5'b11011))
                        begin
                            failed_s = 1'b1;
                        end
                        else
                        begin
                            cp_go  = 1'b1;
                            cp_val = partial_reg[20:0];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Pair surrogates of a complete 16-bit unit
        if (u16_go)
        begin
            if (pend_reg)
            begin
                if (u16[15:10] == 6'b110111)
                begin
                    cp_go  = 1'b1;
                    cp_val = 21'({hs_reg, u16[9:0]}) + 21'h10000;
                    pend_s = 1'b0;
                end
                else
                begin
                    failed_s = 1'b1;
                end
            end
            else if (u16[15:10] == 6'b110110)
            begin
                hs_s   = u16[9:0];
                pend_s = 1'b1;
            end
            else if (u16[15:10] == 6'b110111)
            begin
                failed_s = 1'b1;
            end
            else
            begin
                cp_go  = 1'b1;
                cp_val = {5'd0, u16};
            end
        end

        fail_end = failed_s || ((mode_s == MODE_U16LE || mode_s == MODE_U16BE) && pend_s);

        // Return to the start state after the final word of a file
        if (accept && in_last)
        begin
            mode_next    = MODE_UNDET;
            count_next   = 2'd0;
            held0_next   = held0_reg;
            held1_next   = held1_reg;
            partial_next = 24'd0;
            idx_next     = 2'd0;
            hs_next      = 10'd0;
            pend_next    = 1'b0;
            failed_next  = 1'b0;
        end
        else if (accept)
        begin
            mode_next    = mode_s;
            count_next   = count_s;
            held0_next   = held0_s;
            held1_next   = held1_s;
            partial_next = partial_s;
            idx_next     = idx_s;
            hs_next      = hs_s;
            pend_next    = pend_s;
            failed_next  = failed_s;
        end
        else
        begin
            mode_next    = mode_reg;
            count_next   = count_reg;
            held0_next   = held0_reg;
            held1_next   = held1_reg;
            partial_next = partial_reg;
            idx_next     = idx_reg;
            hs_next      = hs_reg;
            pend_next    = pend_reg;
            failed_next  = failed_reg;
        end
    end

    // Build the queue entry
    always_comb
    begin
        entry.kind = cp_go ? KIND_CP : KIND_RAW;
        entry.cnt  = raw_cnt;
        entry.data = cp_go ? {3'd0, cp_val} : raw_data;
        entry.last = in_last;
        entry.err  = 1'b0;

        if (in_last)
        begin
            // Flush start bytes still held, unless they already count as UTF-16LE
            if (mode_s == MODE_UNDET && !(held0_s == BOM_FF && count_s >= 2'd2))
            begin
                entry.kind = KIND_RAW;
                entry.cnt  = count_s;
                entry.data = {8'd0, held1_s, held0_s};
            end
            if (fail_end)
            begin
                entry.kind = KIND_RAW;
                entry.cnt  = 2'd0;
                entry.data = 24'd0;
                entry.err  = 1'b1;
            end
        end

        push = accept && (in_last || raw_cnt != 2'd0 || cp_go);
    end

    // Hold the decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_UNDET;
            count_reg   <= 2'd0;
            partial_reg <= 24'd0;
            idx_reg     <= 2'd0;
            hs_reg      <= 10'd0;
            pend_reg    <= 1'b0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            partial_reg <= partial_next;
            idx_reg     <= idx_next;
            hs_reg      <= hs_next;
            pend_reg    <= pend_next;
            failed_reg  <= failed_next;
        end
    end

    // Held start bytes need no reset
    always_ff @(posedge clk)
    begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
    end

endmodule

### rtl/bstu_fifo.sv
module bstu_fifo
#(
    parameter int DEPTH = bstu_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bstu_pkg::entry_t wdata,
    input  logic             pop,
    output bstu_pkg::entry_t rdata,
    output logic             full,
    output logic             empty
);
    import bstu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          slots[DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slots[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count out of range");

endmodule

### rtl/bstu_back.sv
module bstu_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  bstu_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             has_byte,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             decode_error
);
    import bstu_pkg::*;

    logic [2:0]  n;
    logic [1:0]  last_idx;
    logic [1:0]  k;
    logic [7:0]  cur_byte;
    logic [5:0]  cont;
    logic [20:0] cp;
    logic        load;
    logic        cur_last;

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic        has_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        err_reg;

    assign cp = head.data[20:0];

    // Count the bytes of the head entry
    always_comb
    begin
        unique case (head.kind)
            KIND_RAW: n = {1'b0, head.cnt};
            KIND_CP:
            begin
                if (cp < 21'h80)
                begin
                    n = 3'd1;
                end
                else if (cp < 21'h800)
                begin
                    n = 3'd2;
                end
                else if (cp < 21'h10000)
                begin
                    n = 3'd3;
                end
                else
                begin
                    n = 3'd4;
                end
            end
            default: n = 3'd0;
        endcase
        last_idx = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
        k        = last_idx - idx_reg;
    end

    // Pick the current output byte
    always_comb
    begin
        unique case (k)
            2'd0:    cont = cp[5:0];
            2'd1:    cont = cp[11:6];
            2'd2:    cont = cp[17:12];
            default: cont = 6'd0;
        endcase

        if (head.kind == KIND_RAW)
        begin
            cur_byte = head.data[8*idx_reg +: 8];
        end
        else if (idx_reg != 2'd0)
        begin
            cur_byte = {2'b10, cont};
        end
        else
        begin
            unique case (n)
                3'd1:    cur_byte = {1'b0, cp[6:0]};
                3'd2:    cur_byte = {3'b110, cp[10:6]};
                3'd3:    cur_byte = {4'b1110, cp[15:12]};
                default: cur_byte = {5'b11110, cp[20:18]};
            endcase
        end
        if (n == 3'd0)
        begin
            cur_byte = 8'd0;
        end
        cur_last = head.last && (idx_reg == last_idx);
    end

    // Advance when the output register is free or being taken
    always_comb
    begin
        load       = !empty && (!valid_reg || !out_stall);
        pop        = load && (idx_reg == last_idx);
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = pop ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            has_reg  <= (n != 3'd0);
            byte_reg <= cur_byte;
            last_reg <= cur_last;
            err_reg  <= head.err && cur_last;
        end
    end

    assign out_valid    = valid_reg;
    assign has_byte     = has_reg;
    assign out_byte     = byte_reg;
    assign out_last     = last_reg;
    assign decode_error = err_reg;

    a_err_is_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && err_reg) |-> (last_reg && !has_reg))
        else $error("error reported on a data word");

    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !has_reg) |-> last_reg)
        else $error("bare marker without end of file");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (idx_reg <= last_idx))
        else $error("byte index beyond entry");

endmodule

### rtl/bom_sniffing_utf_to_utf8_transcoder.sv
// Text transcoder: UTF-16LE, UTF-16BE, UTF-32LE or plain bytes in, UTF-8 out.
// Input channel in_valid/in_stall carries one file byte per word, in_last on
// its final byte. The start of each file is sniffed for a byte-order mark;
// a UTF-8 mark is stripped, an unknown start passes through unchanged.
// Output channel out_valid/out_stall carries one UTF-8 byte per word; the
// final word of a file has out_last set. has_byte low marks a bare end
// word, and decode_error on it means the file held an invalid sequence.
// A front decoder accepts one byte per cycle, while the queue has room, into a
// QUEUE_DEPTH entry queue; the back encoder sends one output byte per cycle
// while entries wait and out_stall does not hold it. An accepted byte is written
// into the queue, and the back loads its output words from the queue head into
// the output register. Each input byte gives zero to four output words (five is
// never reached), so the output port sets the sustained rate.
// in_stall rises while the queue is full; out_stall holds the output word
// and lets the queue fill. Reset empties the queue and returns the decoder
// to the start-of-file state, which the final byte of each file also does.
module bom_sniffing_utf_to_utf8_transcoder
#(
    parameter int QUEUE_DEPTH = bstu_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       has_byte,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       decode_error
);
    import bstu_pkg::*;

    entry_t push_entry;
    entry_t head_entry;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    assign in_stall = full;

    bstu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .queue_full (full),
        .push       (push),
        .entry      (push_entry)
    );

    bstu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_entry),
        .pop   (pop),
        .rdata (head_entry),
        .full  (full),
        .empty (empty)
    );

    bstu_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_entry),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .has_byte     (has_byte),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .decode_error (decode_error)
    );

endmodule

### verif/utf8_stream_checker.sv
`timescale 1ns / 1ps

module utf8_stream_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       has_byte,
    input  logic [7:0] out_byte,
    input  logic       out_last,
    input  logic       decode_error,
    output int         mismatches,
    output int         words_due
);

    import bstu_pkg::*;

    typedef struct packed {
        logic       has;
        logic [7:0] data;
        logic       last;
        logic       err;
    } utf8_word_t;

    // Words still owed by the block, oldest first
    utf8_word_t expected_words[$];
    // Words produced by the byte being decoded
    utf8_word_t step_words[$];

    // Decoder state of the current file
    mode_t       enc_mode;
    logic [2:0]  sniffed;
    logic [7:0]  held [3];
    logic [23:0] partial;
    logic [1:0]  unit_idx;
    logic [9:0]  hi_bits;
    logic        hi_pending;
    logic        file_failed;

    function automatic void clear_file_state();
        enc_mode = MODE_UNDET;
        sniffed = 3'd0;
        held[0] = 8'h00;
        held[1] = 8'h00;
        held[2] = 8'h00;
        partial = 24'h0;
        unit_idx = 2'd0;
        hi_bits = 10'h0;
        hi_pending = 1'b0;
        file_failed = 1'b0;
    endfunction

    // Append a word to those of the current byte
    function automatic void queue_step(input utf8_word_t w);
        step_words.insert(step_words.size(), w);
    endfunction

    // Move the words of the current byte onto the owed list
    function automatic void owe_step_words();
        foreach (step_words[i])
            expected_words.insert(expected_words.size(), step_words[i]);
    endfunction

    function automatic void put_word(input logic has, input logic [7:0] b,
                                     input logic last, input logic err);
        utf8_word_t w;
        w.has = has;
        w.data = b;
        w.last = last;
        w.err = err;
        queue_step(w);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        put_word(1'b1, b, 1'b0, 1'b0);
    endfunction

    // Encode one code point as one to four UTF-8 bytes
    function automatic void encode_cp(input logic [20:0] cp);
        if (cp < 21'h80)
            put_byte(cp[7:0]);
        else if (cp < 21'h800)
        begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
        else
        begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endfunction

    // Pair surrogates; flag lone or unpaired ones
    function automatic void take_unit16(input logic [15:0] u);
        if (hi_pending)
        begin
            if (u >= 16'hDC00 && u <= 16'hDFFF)
            begin
                encode_cp(21'h10000 + {1'b0, hi_bits, u[9:0]});
                hi_pending = 1'b0;
            end
            else
                file_failed = 1'b1;
        end
        else if (u >= 16'hD800 && u <= 16'hDBFF)
        begin
            hi_bits = u[9:0];
            hi_pending = 1'b1;
        end
        else if (u >= 16'hDC00 && u <= 16'hDFFF)
            file_failed = 1'b1;
        else
            encode_cp({5'b0, u});
    endfunction

    // Gather code unit bytes in the current mode
    function automatic void feed_unit(input logic [7:0] b);
        logic [31:0] cp32;
        logic [15:0] unit16;
        if (file_failed)
            return;
        if (enc_mode == MODE_U32LE)
        begin
            if (unit_idx < 2'd3)
            begin
                partial[8 * unit_idx +: 8] = b;
                unit_idx = unit_idx + 2'd1;
            end
            else
            begin
                cp32 = {b, partial};
                partial = 24'h0;
                unit_idx = 2'd0;
                if (cp32 > 32'h10FFFF || (cp32 >= 32'hD800 && cp32 <= 32'hDFFF))
                    file_failed = 1'b1;
                else
                    encode_cp(cp32[20:0]);
            end
        end
        else if (unit_idx == 2'd0)
        begin
            partial = {16'h0, b};
            unit_idx = 2'd1;
        end
        else
        begin
            unit16 = (enc_mode == MODE_U16LE) ? {b, partial[7:0]} : {partial[7:0], b};
            partial = 24'h0;
            unit_idx = 2'd0;
            take_unit16(unit16);
        end
    endfunction

    function automatic void pass_held(input logic [7:0] b);
        for (int i = 0; i < sniffed && i < 3; i++)
            put_byte(held[2'(i)]);
        put_byte(b);
        enc_mode = MODE_PASS;
    endfunction

    function automatic void hold_start(input logic [7:0] b);
        if (sniffed < 3'd3)
            held[sniffed[1:0]] = b;
        sniffed = sniffed + 3'd1;
    endfunction

    // Match the start of the file against the byte-order marks
    function automatic void sniff_start(input logic [7:0] b);
        logic [7:0] first;
        first = held[0];
        if (sniffed == 3'd0)
        begin
            if (b == BOM_FF || b == BOM_FE || b == BOM_EF)
                hold_start(b);
            else
                pass_held(b);
        end
        else if (sniffed == 3'd1)
        begin
            if ((first == BOM_FF && b == BOM_FE) || (first == BOM_EF && b == BOM_BB))
                hold_start(b);
            else if (first == BOM_FE && b == BOM_FF)
                enc_mode = MODE_U16BE;
            else
                pass_held(b);
        end
        else if (sniffed == 3'd2)
        begin
            if (first == BOM_FF)
            begin
                if (b == BOM_00)
                    hold_start(b);
                else
                begin
                    enc_mode = MODE_U16LE;
                    feed_unit(b);
                end
            end
            else if (b == BOM_BF)
                enc_mode = MODE_PASS;
            else
                pass_held(b);
        end
        else if (b == BOM_00)
            enc_mode = MODE_U32LE;
        else
        begin
            enc_mode = MODE_U16LE;
            feed_unit(BOM_00);
            feed_unit(b);
        end
    endfunction

    // Work out the words that one file byte gives and queue them
    function automatic void predict_utf8(input logic [7:0] b, input logic last);
        step_words.delete();
        if (enc_mode == MODE_UNDET)
            sniff_start(b);
        else if (enc_mode == MODE_PASS)
            put_byte(b);
        else
            feed_unit(b);

        if (!last)
        begin
            if (!file_failed)
                owe_step_words();
            return;
        end

        // Release held start bytes unless they already count as UTF-16LE
        if (enc_mode == MODE_UNDET && !(held[0] == BOM_FF && sniffed >= 3'd2))
            for (int i = 0; i < sniffed && i < 3; i++)
                put_byte(held[2'(i)]);
        if ((enc_mode == MODE_U16LE || enc_mode == MODE_U16BE) && hi_pending)
            file_failed = 1'b1;

        if (file_failed)
        begin
            step_words.delete();
            put_word(1'b0, 8'h00, 1'b1, 1'b1);
        end
        else if (step_words.size() == 0)
            put_word(1'b0, 8'h00, 1'b1, 1'b0);
        else
            step_words[step_words.size() - 1].last = 1'b1;
        owe_step_words();
        clear_file_state();
    endfunction

    // Predict on accepted input words, compare accepted output words
    // (fields shown as has_byte out_byte out_last decode_error)
    always @(posedge clk or negedge rst_n)
    begin
        utf8_word_t due;
        if (!rst_n)
        begin
            clear_file_state();
            expected_words.delete();
            mismatches = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_utf8(in_byte, in_last);
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word %0b %02h %0b %0b",
                                 $realtime, has_byte, out_byte, out_last, decode_error);
                end
                else
                begin
                    due = expected_words.pop_front();
                    if (has_byte !== due.has || out_byte !== due.data ||
                        out_last !== due.last || decode_error !== due.err)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected %0b %02h %0b %0b, got %0b %02h %0b %0b",
                                     $realtime, due.has, due.data, due.last, due.err,
                                     has_byte, out_byte, out_last, decode_error);
                    end
                end
            end
        end
        words_due = expected_words.size();
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import bstu_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BYTES_PER_PHASE = 44;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       has_byte;
    logic [7:0] out_byte;
    logic       out_last;
    logic       decode_error;

    int mismatches;
    int words_due;
    int sender_idle = 0;
    int receiver_stall = 0;
    int quiet_cycles = 0;

    // Bytes of the file about to be sent
    logic [7:0] file_bytes[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bom_sniffing_utf_to_utf8_transcoder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .has_byte     (has_byte),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .decode_error (decode_error)
    );

    utf8_stream_checker stream_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .has_byte     (has_byte),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .decode_error (decode_error),
        .mismatches   (mismatches),
        .words_due    (words_due)
    );

    // Stall the output at random
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < receiver_stall);

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one word, idling first at random; hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < sender_idle)
        begin
            in_valid <= 1'b0;
            in_byte <= 8'($urandom_range(255));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_word(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Code point from a random size class, edges included
    function automatic logic [20:0] pick_cp();
        logic [20:0] cp;
        case ($urandom_range(4))
            0: cp = 21'($urandom_range(8'h7F, 0));
            1: cp = 21'($urandom_range(16'h7FF, 8'h80));
            2:
            begin
                if ($urandom_range(1) == 0)
                    cp = 21'($urandom_range(16'hD7FF, 16'h800));
                else
                    cp = 21'($urandom_range(16'hFFFF, 16'hE000));
            end
            3: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            default:
            begin
                case ($urandom_range(7))
                    0: cp = 21'h0;
                    1: cp = 21'h7F;
                    2: cp = 21'h80;
                    3: cp = 21'h7FF;
                    4: cp = 21'h800;
                    5: cp = 21'hFFFF;
                    6: cp = 21'h10000;
                    default: cp = 21'h10FFFF;
                endcase
            end
        endcase
        return cp;
    endfunction

    // Append one byte to the file being built
    function automatic void add_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic void put_unit16(input logic [15:0] u, input logic big);
        if (big)
        begin
            add_byte(u[15:8]);
            add_byte(u[7:0]);
        end
        else
        begin
            add_byte(u[7:0]);
            add_byte(u[15:8]);
        end
    endfunction

    function automatic void put_cp16(input logic [20:0] cp, input logic big);
        logic [20:0] offset;
        offset = cp - 21'h10000;
        if (cp >= 21'h10000)
        begin
            put_unit16({6'b110110, offset[19:10]}, big);
            put_unit16({6'b110111, offset[9:0]}, big);
        end
        else
            put_unit16(cp[15:0], big);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        case ($urandom_range(6))
            0: b = BOM_FF;
            1: b = BOM_FE;
            2: b = BOM_EF;
            3: b = BOM_BB;
            4: b = BOM_BF;
            5: b = BOM_00;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    // Build a random file: mostly well-formed text behind a mark, some noise
    function automatic void build_random_file();
        int pick;
        int units;
        logic big;
        logic [31:0] raw;
        file_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            big = (pick >= 25);
            if (big)
            begin
                add_byte(BOM_FE);
                add_byte(BOM_FF);
            end
            else
            begin
                add_byte(BOM_FF);
                add_byte(BOM_FE);
            end
            units = $urandom_range(5, 1);
            for (int i = 0; i < units; i++)
            begin
                case ($urandom_range(11))
                    // lone low surrogate
                    0: put_unit16(16'($urandom_range(16'hDFFF, 16'hDC00)), big);
                    // high surrogate not followed by a low one
                    1:
                    begin
                        put_unit16(16'($urandom_range(16'hDBFF, 16'hD800)), big);
                        put_unit16(16'($urandom_range(16'hD7FF, 16'h0)), big);
                    end
                    default: put_cp16(pick_cp(), big);
                endcase
            end
            if ($urandom_range(9) == 0)
                put_unit16(16'($urandom_range(16'hDBFF, 16'hD800)), big);
            if ($urandom_range(9) == 0)
                add_byte(8'($urandom_range(255)));
        end
        else if (pick < 65)
        begin
            add_byte(BOM_FF);
            add_byte(BOM_FE);
            add_byte(BOM_00);
            add_byte(BOM_00);
            units = $urandom_range(4, 1);
            for (int i = 0; i < units; i++)
            begin
                case ($urandom_range(9))
                    0: raw = $urandom_range(32'hFFFFFFFF, 32'h110000);
                    1: raw = $urandom_range(32'hDFFF, 32'hD800);
                    default: raw = {11'h0, pick_cp()};
                endcase
                for (int k = 0; k < 4; k++)
                    add_byte(raw[8 * k +: 8]);
            end
            if ($urandom_range(7) == 0)
            begin
                units = $urandom_range(3, 1);
                for (int i = 0; i < units; i++)
                    add_byte(8'($urandom_range(255)));
            end
        end
        else if (pick < 75)
        begin
            add_byte(BOM_EF);
            add_byte(BOM_BB);
            add_byte(BOM_BF);
            units = $urandom_range(5, 0);
            for (int i = 0; i < units; i++)
                add_byte(8'($urandom_range(255)));
        end
        else if (pick < 85)
        begin
            units = $urandom_range(6, 1);
            for (int i = 0; i < units; i++)
                add_byte(8'($urandom_range(255)));
        end
        else
        begin
            units = $urandom_range(4, 1);
            for (int i = 0; i < units; i++)
                add_byte(noise_byte());
        end
    endfunction

    initial
    begin
        int sent;
        int waited;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed files under moderate idling on both sides
        sender_idle = 36;
        receiver_stall = 36;
        // UTF-16LE euro sign, then a dropped partial unit and a bare end word
        file_bytes = '{BOM_FF, BOM_FE, 8'hAC, 8'h20, 8'hDC};
        send_file();
        // UTF-16BE surrogate pair
        file_bytes = '{BOM_FE, BOM_FF, 8'hD8, 8'h3D, 8'hDE, 8'h00};
        send_file();
        // short file ending inside the UTF-32 mark
        file_bytes = '{BOM_FF, BOM_FE, BOM_00};
        send_file();
        // UTF-8 mark alone
        file_bytes = '{BOM_EF, BOM_BB, BOM_BF};
        send_file();
        file_bytes = '{8'h00};
        send_file();
        // high surrogate left pending at the end
        file_bytes = '{BOM_FF, BOM_FE, 8'h3D, 8'hD8};
        send_file();
        // UTF-32 surrogate value
        file_bytes = '{BOM_FF, BOM_FE, BOM_00, BOM_00, 8'h00, 8'hD8, 8'h00, 8'h00};
        send_file();

        // Random files across the idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle = 0;
                    receiver_stall = 0;
                end
                1:
                begin
                    sender_idle = 83;
                    receiver_stall = 0;
                end
                2:
                begin
                    sender_idle = 0;
                    receiver_stall = 83;
                end
                default:
                begin
                    sender_idle = 36;
                    receiver_stall = 36;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_BYTES_PER_PHASE)
            begin
                build_random_file();
                sent += file_bytes.size();
                send_file();
            end
        end
        in_valid <= 1'b0;

        // Drain what is still owed, then let the block settle
        waited = 0;
        while (words_due != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatches == 0 && words_due == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### bom_sniffing_utf_to_utf8_transcoder.f
rtl/bstu_pkg.sv
rtl/bstu_front.sv
rtl/bstu_fifo.sv
rtl/bstu_back.sv
rtl/bom_sniffing_utf_to_utf8_transcoder.sv
verif/utf8_stream_checker.sv
verif/testbench.sv
